>>> rtl/s2da_pkg.sv
// ----------------------------------------------------------------------------
// s2da_pkg: shared types and constants
// Widths, character codes, register indexes and the job record that the
// front end hands to the character emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package s2da_pkg;

    // Input value width and the largest buffer size that is honored.
    localparam int VALUE_BITS = 32;
    localparam int MAX_BUFFER = 64;

    // Decimal digits needed for a magnitude of up to 2^(VALUE_BITS-1).
    localparam int MAX_DIGITS = 10;
    localparam int NDIG_BITS  = $clog2(MAX_DIGITS + 1);

    // Field widths of the channels.
    localparam int CHAR_BITS  = 7;
    localparam int LEN_BITS   = 6;
    localparam int BUF_BITS   = 7;
    localparam int MIND_BITS  = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DIGITS  = 2'd1;

    // Reset values of the registers.
    localparam logic [BUF_BITS-1:0]  BUFFER_SIZE_RST = 7'd8;
    localparam logic [MIND_BITS-1:0] MIN_DIGITS_RST  = 6'd0;

    // Character codes.
    localparam logic [CHAR_BITS-1:0] ASCII_ZERO  = 7'd48;
    localparam logic [CHAR_BITS-1:0] ASCII_MINUS = 7'd45;
    localparam logic [CHAR_BITS-1:0] ASCII_NUL   = 7'd0;

    // Division by ten as multiply by ceil(2^35 / 10) and shift by 35.
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // One converted number: sign and digits, least significant first.
    typedef struct packed {
        logic                          neg;
        logic [NDIG_BITS-1:0]          nd;
        logic [MAX_DIGITS-1:0][3:0]    digits;
    } t_job;

endpackage

`default_nettype wire

>>> rtl/s2da_if.sv
// ----------------------------------------------------------------------------
// s2da_if: channel interfaces
// Valid/ready channels for input values, output characters and register
// writes. A beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface s2da_in_if;
    import s2da_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface s2da_out_if;
    import s2da_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CHAR_BITS-1:0] out_char;
    logic                 is_last;
    logic                 failed;
    logic [LEN_BITS-1:0]  total_length;
    modport source (output valid, output out_char, output is_last, output failed,
                    output total_length, input ready);
    modport sink   (input valid, input out_char, input is_last, input failed,
                    input total_length, output ready);
endinterface

interface s2da_cfg_if;
    import s2da_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII characters
// Holds the configuration registers and joins the digit extractor, the job
// queue and the character emitter.
// ----------------------------------------------------------------------------
// Usage:
//   i_value_ch takes one signed 32-bit value per beat. o_char_ch returns its
//   decimal string one character per beat, most significant first, with
//   is_last on the final one and total_length on every one. A string that
//   does not fit the buffer size returns a single beat with failed set.
//   i_cfg_ch writes buffer_size (index 0) and min_digits (index 1), is always
//   ready; the user writes only while the block is idle (not enforced here).
// Flow:
//   The front end accepts a value, peels off one decimal digit per cycle
//   (1 to 10) through the divide-by-ten multiplier, and then hands the job
//   over. The emitter sets up each job and then sends one character per
//   cycle while the receiver is ready. A two-entry queue lets the next
//   value be converted while characters of the last one still go out.
// Reset and stall:
//   Reset empties the queue and restores buffer_size 8 and min_digits 0.
//   A stalled receiver holds the output register; the queue then fills and
//   i_value_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_decimal_ascii
    import s2da_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    s2da_in_if.sink   i_value_ch,
    s2da_cfg_if.sink  i_cfg_ch,
    s2da_out_if.source o_char_ch
);

    logic [BUF_BITS-1:0]  r_buffer_size;
    logic [MIND_BITS-1:0] r_min_digits;
    logic [BUF_BITS-1:0]  cap;

    logic front_valid, front_ready;
    t_job front_job;
    logic back_valid, back_ready;
    t_job back_job;

    // Configuration registers; writes to unknown indexes are dropped.
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUFFER_SIZE_RST;
            r_min_digits  <= MIN_DIGITS_RST;
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                REG_BUFFER_SIZE: r_buffer_size <= i_cfg_ch.data;
                REG_MIN_DIGITS:  r_min_digits  <= i_cfg_ch.data[MIND_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Buffer size is limited to the largest supported buffer.
    assign cap = (r_buffer_size > BUF_BITS'(MAX_BUFFER)) ?
                 BUF_BITS'(MAX_BUFFER) : r_buffer_size;

    s2da_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_value_ch.valid),
        .i_value     (i_value_ch.value),
        .o_ready     (i_value_ch.ready),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (front_ready)
    );

    s2da_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_job   (front_job),
        .o_push_ready (front_ready),
        .o_pop_valid  (back_valid),
        .o_pop_job    (back_job),
        .i_pop_ready  (back_ready)
    );

    s2da_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cap        (cap),
        .i_min_digits (r_min_digits),
        .i_job_valid  (back_valid),
        .i_job        (back_job),
        .o_job_ready  (back_ready),
        .o_valid      (o_char_ch.valid),
        .o_char       (o_char_ch.out_char),
        .o_last       (o_char_ch.is_last),
        .o_failed     (o_char_ch.failed),
        .o_length     (o_char_ch.total_length),
        .i_ready      (o_char_ch.ready)
    );

endmodule

`default_nettype wire

>>> rtl/s2da_front.sv
// ----------------------------------------------------------------------------
// s2da_front: sign split and digit extraction
// Takes one value, forms its magnitude and peels off one decimal digit per
// cycle, then pushes the finished job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module s2da_front
    import s2da_pkg::*;
(
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic signed [VALUE_BITS-1:0] i_value,
    output logic                              o_ready,
    output logic                              o_job_valid,
    output t_job                              o_job,
    input  wire logic                         i_job_ready
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    logic [1:0]                 r_state, n_state;
    logic [VALUE_BITS-1:0]      r_mag, n_mag;
    logic                       r_neg, n_neg;
    logic [NDIG_BITS-1:0]       r_nd, n_nd;
    logic [MAX_DIGITS-1:0][3:0] r_digits, n_digits;

    logic [63:0]           prod;
    logic [VALUE_BITS-1:0] quot;
    logic [VALUE_BITS-1:0] rem;

    // One division by ten per cycle through a reciprocal multiply.
    assign prod = 64'(r_mag) * 64'(RECIP_TEN);
    assign quot = VALUE_BITS'(prod >> RECIP_SHIFT);
    assign rem  = r_mag - ((quot << 3) + (quot << 1));

    assign o_ready     = (r_state == ST_IDLE);
    assign o_job_valid = (r_state == ST_PUSH);
    assign o_job       = '{neg: r_neg, nd: r_nd, digits: r_digits};

    // Sequencer: accept, extract digits, hand over.
    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_nd     = r_nd;
        n_digits = r_digits;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[VALUE_BITS-1];
                    n_mag   = i_value[VALUE_BITS-1] ? (~i_value + 1'b1) : i_value;
                    n_nd    = '0;
                    n_state = ST_CONV;
                end
            end
            ST_CONV: begin
                n_digits[r_nd] = rem[3:0];
                n_nd           = r_nd + 1'b1;
                n_mag          = quot;
                if (quot == '0) begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (i_job_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_nd     <= n_nd;
        r_digits <= n_digits;
    end

endmodule

`default_nettype wire

>>> rtl/s2da_queue.sv
// ----------------------------------------------------------------------------
// s2da_queue: two-entry job queue
// Decouples digit extraction from character emission; up to two jobs wait
// here, so one side can stall without at once holding up the other.
// ----------------------------------------------------------------------------
`default_nettype none

module s2da_queue
    import s2da_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    input  t_job      i_push_job,
    output logic      o_push_ready,
    output logic      o_pop_valid,
    output t_job      o_pop_job,
    input  wire logic i_pop_ready
);

    t_job       r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       push, pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/s2da_back.sv
// ----------------------------------------------------------------------------
// s2da_back: length check and character emission
// Pops a job, checks the padded length plus one against the buffer size
// and sends the characters one beat at a time through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module s2da_back
    import s2da_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [BUF_BITS-1:0]  i_cap,
    input  wire logic [MIND_BITS-1:0] i_min_digits,
    input  wire logic                 i_job_valid,
    input  t_job                      i_job,
    output logic                      o_job_ready,
    output logic                      o_valid,
    output logic [CHAR_BITS-1:0]      o_char,
    output logic                      o_last,
    output logic                      o_failed,
    output logic [LEN_BITS-1:0]       o_length,
    input  wire logic                 i_ready
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                 r_state, n_state;
    t_job                 r_job, n_job;
    logic [LEN_BITS:0]    r_len, n_len;
    logic [LEN_BITS-1:0]  r_width, n_width;
    logic                 r_fail, n_fail;
    logic [LEN_BITS-1:0]  r_pos, n_pos;

    logic                 r_ovalid, n_ovalid;
    logic [CHAR_BITS-1:0] r_ochar, n_ochar;
    logic                 r_olast, n_olast;
    logic                 r_ofail, n_ofail;
    logic [LEN_BITS-1:0]  r_olen, n_olen;

    logic [LEN_BITS-1:0]  job_width;
    logic [LEN_BITS-1:0]  pos_in_num;
    logic [LEN_BITS-1:0]  pad;
    logic [LEN_BITS-1:0]  dig_idx;
    logic [CHAR_BITS-1:0] cur_char;
    logic                 cur_last;
    logic                 slot_free;

    // Digit count after padding for the job at the queue head.
    assign job_width = (LEN_BITS'(i_job.nd) > i_min_digits) ?
                       LEN_BITS'(i_job.nd) : i_min_digits;

    // Character at the current position: sign, padding zero or digit.
    always_comb begin
        pos_in_num = r_pos - LEN_BITS'(r_job.neg);
        pad        = r_width - LEN_BITS'(r_job.nd);
        dig_idx    = r_width - 1'b1 - pos_in_num;
        if (r_job.neg && (r_pos == '0)) begin
            cur_char = ASCII_MINUS;
        end else if (pos_in_num < pad) begin
            cur_char = ASCII_ZERO;
        end else begin
            cur_char = ASCII_ZERO + CHAR_BITS'(r_job.digits[dig_idx[NDIG_BITS-1:0]]);
        end
        cur_last = ((LEN_BITS + 1)'(r_pos) + 1'b1 == r_len);
    end

    assign slot_free   = !r_ovalid || i_ready;
    assign o_job_ready = (r_state == ST_IDLE);

    assign o_valid  = r_ovalid;
    assign o_char   = r_ochar;
    assign o_last   = r_olast;
    assign o_failed = r_ofail;
    assign o_length = r_olen;

    // Job setup and per-beat emission.
    always_comb begin
        n_state  = r_state;
        n_job    = r_job;
        n_len    = r_len;
        n_width  = r_width;
        n_fail   = r_fail;
        n_pos    = r_pos;
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        n_ofail  = r_ofail;
        n_olen   = r_olen;
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_width = job_width;
                    n_len   = (LEN_BITS + 1)'(job_width) + (LEN_BITS + 1)'(i_job.neg);
                    n_fail  = ((LEN_BITS + 2)'(n_len) + 1'b1) > (LEN_BITS + 2)'(i_cap);
                    n_pos   = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_ovalid = 1'b1;
                    if (r_fail) begin
                        n_ochar = ASCII_NUL;
                        n_olast = 1'b1;
                        n_ofail = 1'b1;
                        n_olen  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_ochar = cur_char;
                        n_olast = cur_last;
                        n_ofail = 1'b0;
                        n_olen  = r_len[LEN_BITS-1:0];
                        n_pos   = r_pos + 1'b1;
                        if (cur_last) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_job   <= n_job;
        r_len   <= n_len;
        r_width <= n_width;
        r_fail  <= n_fail;
        r_pos   <= n_pos;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_ofail <= n_ofail;
        r_olen  <= n_olen;
    end

endmodule

`default_nettype wire
